/* hdl/rhht_pkg.sv */
// Shared types and constants for the Robin Hood hash table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package rhht_pkg;
    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BYTES = 8;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam int          LOAD_NUM  = 3;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, start hash
        logic hash_step; // one byte of FNV
        logic rd;        // issue read of slot at r_pos
        logic ins_eval;  // evaluate insert step on read data
        logic find_eval; // evaluate find step on read data
        logic del_eval;  // evaluate backward shift step on read data
        logic del_start; // start shift at found slot
        logic wr_clear;  // write unused at hole
        logic cnt_inc;
        logic cnt_dec;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic       hash_last;
        logic       full;
        logic       ins_done;  // free slot written
        logic       find_hit;
        logic       find_miss;
        logic       del_stop;  // next slot ends the shift
        logic       probe_end; // probe bound reached
        logic [1:0] cmd;
    } t_sts;
endpackage

/* hdl/rhht_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

/* hdl/rhht_ctrl.sv */
// Controller state machine for the hash table: sequences hash, probe and
// shift steps. Depends on rhht_pkg.
`timescale 1ns / 1ps
module rhht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic           i_out_busy,
    output logic           o_ready,
    output logic           o_done,
    input  rhht_pkg::t_sts i_sts,
    output rhht_pkg::t_ctl o_ctl
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DEL  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DEV  = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_ctl.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    if (i_sts.cmd == rhht_pkg::CMD_INSERT && i_sts.full) begin
                        n_state = S_RESP;
                    end else if (i_sts.cmd inside {rhht_pkg::CMD_INSERT,
                                                   rhht_pkg::CMD_LOOKUP,
                                                   rhht_pkg::CMD_REMOVE}) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.cmd == rhht_pkg::CMD_INSERT) begin
                    o_ctl.ins_eval = 1'b1;
                    if (i_sts.ins_done) begin
                        o_ctl.cnt_inc = 1'b1;
                        n_state       = S_RESP;
                    end else if (i_sts.probe_end) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    o_ctl.find_eval = 1'b1;
                    if (i_sts.find_hit) begin
                        if (i_sts.cmd == rhht_pkg::CMD_REMOVE) begin
                            o_ctl.del_start = 1'b1;
                            o_ctl.cnt_dec   = 1'b1;
                            n_state         = S_DRD;
                        end else begin
                            n_state = S_RESP;
                        end
                    end else if (i_sts.find_miss || i_sts.probe_end) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_DRD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_DEV;
            end
            S_DEV: begin
                o_ctl.del_eval = 1'b1;
                if (i_sts.del_stop || i_sts.probe_end) begin
                    n_state = S_DEL;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_DEL: begin
                o_ctl.wr_clear = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (!i_out_busy) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* hdl/rhht_dp.sv */
// Datapath: item registers, iterative FNV hash, slot memory, probe logic.
// Depends on rhht_pkg and rhht_ram.
`timescale 1ns / 1ps
module rhht_dp #(
    parameter int CAPACITY    = rhht_pkg::DEF_CAPACITY,
    parameter int KEY_BYTES   = rhht_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = rhht_pkg::DEF_VALUE_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_cmd,
    input  logic [63:0]    i_key,
    input  logic [63:0]    i_value,
    input  rhht_pkg::t_ctl i_ctl,
    output rhht_pkg::t_sts o_sts,
    output logic [1:0]     o_status,
    output logic [63:0]    o_read_value
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(KEY_BYTES + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam int VW = 8 * VALUE_BYTES;
    localparam int EW = 1 + AW + 64 + KW + VW; // used, dist, hash, key, value
    localparam logic [CW+1:0] FULL_AT = (CW+2)'(CAPACITY * rhht_pkg::LOAD_NUM);

    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [63:0]   r_hash, r_h;
    logic [AW-1:0] r_dist;
    logic [BW-1:0] r_byte;
    logic [AW-1:0] r_pos, r_hole;
    logic [AW:0]   r_steps;
    logic [CW-1:0] r_count;
    logic [1:0]    r_status;
    logic [63:0]   r_rv;

    // memory: one row per slot, used bit included (cleared by valid bits below)
    logic          r_valid [CAPACITY];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic          r_rd_valid;

    rhht_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    logic          e_used;
    logic [AW-1:0] e_dist;
    logic [63:0]   e_hash;
    logic [KW-1:0] e_key;
    logic [VW-1:0] e_val;
    assign {e_used, e_dist, e_hash, e_key, e_val} = mem_rdata;
    logic used_rd;
    assign used_rd = e_used && r_rd_valid;

    // FNV step: x * prime, prime = 2^40 + 0x1B3
    logic [63:0] hx, hmul;
    assign hx   = r_h ^ {56'd0, r_key[8*r_byte[BW-1:0] +: 8]};
    assign hmul = (hx << 40) + (hx * 64'h1B3);

    logic [AW:0] dist_ext, edist_ext;
    assign dist_ext  = {1'b0, r_dist};
    assign edist_ext = {1'b0, e_dist};

    always_comb begin
        o_sts           = '0;
        o_sts.cmd       = r_cmd;
        o_sts.hash_last = (r_byte == BW'(KEY_BYTES - 1));
        o_sts.full      = ({2'b00, r_count} << 2) >= FULL_AT;
        o_sts.probe_end = (r_steps == (AW+1)'(CAPACITY - 1));
        o_sts.ins_done  = !used_rd;
        o_sts.find_miss = !used_rd || (dist_ext > edist_ext);
        o_sts.find_hit  = used_rd && !(dist_ext > edist_ext) &&
                          e_hash == r_hash && e_key == r_key;
        o_sts.del_stop  = !used_rd || e_dist == '0;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pos;
        mem_wdata = {1'b1, r_dist, r_hash, r_key, r_val};
        if (i_ctl.ins_eval && (!used_rd || dist_ext > edist_ext)) begin
            mem_we = 1'b1;
        end
        if (i_ctl.del_eval && !o_sts.del_stop) begin
            mem_we    = 1'b1;
            mem_addr  = r_hole;
            mem_wdata = {1'b1, e_dist - AW'(1), e_hash, e_key, e_val};
        end
        if (i_ctl.wr_clear) begin
            mem_we    = 1'b1;
            mem_addr  = r_hole;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) r_valid[i] <= 1'b0;
        end else begin
            // track the slot read alongside the memory data
            if (i_ctl.rd) r_rd_valid <= r_valid[mem_addr];
            if (mem_we) r_valid[mem_addr] <= 1'b1;
            if (i_ctl.cnt_inc) r_count <= r_count + CW'(1);
            if (i_ctl.cnt_dec && r_count != '0) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_key    <= i_key[KW-1:0];
            r_val    <= i_value[VW-1:0];
            r_h      <= rhht_pkg::FNV_BASIS;
            r_byte   <= '0;
            r_dist   <= '0;
            r_steps  <= '0;
            r_status <= rhht_pkg::ST_MISS;
            r_rv     <= '0;
        end
        if (i_ctl.hash_step) begin
            r_h    <= hmul;
            r_byte <= r_byte + BW'(1);
            if (o_sts.hash_last) begin
                r_hash <= hmul;
                r_pos  <= hmul[AW-1:0];
                if (r_cmd == rhht_pkg::CMD_INSERT && o_sts.full) begin
                    r_status <= rhht_pkg::ST_FULL;
                end
            end
        end
        if (i_ctl.ins_eval) begin
            if (!used_rd) begin
                r_status <= rhht_pkg::ST_OK;
            end else begin
                if (dist_ext > edist_ext) begin
                    r_key  <= e_key;
                    r_val  <= e_val;
                    r_hash <= e_hash;
                    r_dist <= e_dist + AW'(1);
                end else begin
                    r_dist <= r_dist + AW'(1);
                end
                r_pos   <= r_pos + AW'(1);
                r_steps <= r_steps + (AW+1)'(1);
            end
        end
        if (i_ctl.find_eval) begin
            if (o_sts.find_hit) begin
                r_status <= rhht_pkg::ST_OK;
                if (r_cmd == rhht_pkg::CMD_LOOKUP) r_rv <= 64'(e_val);
            end
            r_dist <= r_dist + AW'(1);
            r_pos  <= r_pos + AW'(1);
            // restart the step count when the shift begins
            if (i_ctl.del_start) begin
                r_steps <= '0;
            end else begin
                r_steps <= r_steps + (AW+1)'(1);
            end
        end
        if (i_ctl.del_start) begin
            r_hole <= r_pos;
        end
        if (i_ctl.del_eval) begin
            if (!o_sts.del_stop) begin
                r_hole <= r_pos;
                r_pos  <= r_pos + AW'(1);
            end
            r_steps <= r_steps + (AW+1)'(1);
        end
    end

    assign o_status     = r_status;
    assign o_read_value = r_rv;
endmodule

/* hdl/robin_hood_hash_table.sv */
// Top level of the Robin Hood hash table: stream ports, output register.
// Depends on rhht_pkg, rhht_ctrl, rhht_dp.
//
//  channel  | dir | tdata                               | tuser
//  s_axis   | in  | [1:0] cmd, [65:2] key, [129:66] val | -
//  m_axis   | out | [1:0] status, [65:2] read_value     | -
//
// An item goes through an accept step, one hash step per key byte, a memory read
// then an update for each probed slot, on remove a read then an update for each
// slot read in the shift plus a step to clear the hole, and a response step. A
// refused insert goes straight from hashing to the response.
// Reset clears the used marks (one flip-flop per slot) and the count at once.
// One item at a time; a stalled result holds in the output register.
`timescale 1ns / 1ps
module robin_hood_hash_table #(
    parameter int CAPACITY    = rhht_pkg::DEF_CAPACITY,
    parameter int KEY_BYTES   = rhht_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = rhht_pkg::DEF_VALUE_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // cmd, key, value, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // status, read_value, zero fill
);
    rhht_pkg::t_ctl ctl;
    rhht_pkg::t_sts sts;
    logic        in_fire, done, ready;
    logic [1:0]  status;
    logic [63:0] rv;
    logic        r_ovalid;
    logic [65:0] r_odata;

    assign in_fire = s_axis_tvalid && ready;
    assign s_axis_tready = ready;

    rhht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_out_busy(r_ovalid && !m_axis_tready),
        .o_ready   (ready),
        .o_done    (done),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    rhht_dp #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES),
              .VALUE_BYTES(VALUE_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_axis_tdata[1:0]),
        .i_key       (s_axis_tdata[65:2]),
        .i_value     (s_axis_tdata[129:66]),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_status    (status),
        .o_read_value(rv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_odata <= {rv, status};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};
endmodule

/* hdl/rhht_checker.sv */
// Port-level checker for robin_hood_hash_table, bound to the top level.
// Depends on rhht_pkg.
`timescale 1ns / 1ps
module rhht_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] <= rhht_pkg::ST_FULL)
        else $error("bad status code");
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != rhht_pkg::ST_OK |-> m_axis_tdata[65:2] == '0)
        else $error("read value not zero on failure");
endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
